// File: design/mdl_pkg.sv
// ----------------------------------------------------------------------------
// mdl_pkg
// Shared types, constants and register codes for the masked dense layer.
// ----------------------------------------------------------------------------
package mdl_pkg;

  localparam int MAX_INPUTS  = 16;
  localparam int MAX_OUTPUTS = 16;
  localparam int COL_W = $clog2(MAX_INPUTS);
  localparam int ROW_W = $clog2(MAX_OUTPUTS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int MASK_ONE = 16384;

  // Full-precision accumulator: 32-bit products over up to MAX_INPUTS terms
  localparam int ACC_W = 33 + COL_W;

  typedef enum logic [1:0] {
    FN_WEIGHT  = 2'd0,
    FN_MASK    = 2'd1,
    FN_BIAS    = 2'd2,
    FN_FEATURE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_THRESH = 2'd1,
    REG_NIN    = 2'd2,
    REG_NOUT   = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // Control that travels along the cell chain with each term
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [ROW_W-1:0]  row;
  } tag_t;

endpackage

// File: design/mdl_ram.sv
// ----------------------------------------------------------------------------
// mdl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module mdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mdl_cell.sv
// ----------------------------------------------------------------------------
// mdl_cell
// One stage of the MAC chain: multiplies, with an optional floor shift by 14 (masks or multiplies).
// ----------------------------------------------------------------------------
module mdl_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mdl_pkg::tag_t             tag_in,
  input  logic signed [mdl_pkg::ACC_W-1:0] a_in,
  input  logic signed [16:0]        b_in,
  input  logic                      shift14,
  output mdl_pkg::tag_t             tag_out,
  output logic signed [mdl_pkg::ACC_W-1:0] p_out
);

  logic signed [mdl_pkg::ACC_W+17-1:0] prod;
  logic signed [mdl_pkg::ACC_W-1:0] p_r, p_nxt;
  mdl_pkg::tag_t tag_r;

  // Multiply and optionally floor-shift by 14
  always_comb begin
    prod = a_in * b_in;
    if (shift14) begin
      p_nxt = mdl_pkg::ACC_W'(prod >>> 14);
    end else begin
      p_nxt = mdl_pkg::ACC_W'(prod);
    end
  end

  // Hold product and tag for the neighbour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
    end else begin
      tag_r.valid <= tag_in.valid;
    end
    tag_r.first <= tag_in.first;
    tag_r.last  <= tag_in.last;
    tag_r.row   <= tag_in.row;
    p_r <= p_nxt;
  end

  assign tag_out = tag_r;
  assign p_out   = p_r;

endmodule

// File: design/masked_dense_layer_forward.sv
// ----------------------------------------------------------------------------
// masked_dense_layer_forward
// Masked fully connected layer, Q8.8, one shared multiply chain.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                         | tuser / tlast
// in_     | in  | row[3:0] col[7:4] value[23:8]               | func[1:0], tlast=last_feature
// out_    | out | out_row[3:0] value[19:4] path_on[20] sat[21]| tlast=last_row
// cfg_    | in  | APB, gain 0x0, threshold 0x4, n_in 0x8, n_out 0xC
// Writes and non-last features are accepted while idle. A last feature holds in_tready
// low while n_in*n_out terms issue through the cell chain (memory read, mask cell,
// feature cell, accumulate, scale cell) and then while the chain drains; one row per n_in.
// Issue pauses while queued plus in-flight rows reach the 4-deep result queue, so
// out_tready stalls, and for small n_in the chain latency, lengthen the run.
// After reset the mask RAM is swept to 1.0 in all 256 entries, inputs held off.
// ----------------------------------------------------------------------------
module masked_dense_layer_forward (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row, col, value
  input  logic [1:0]  in_tuser,   // func
  input  logic        in_tlast,   // last_feature
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_row, out_value, path_on, saturated
  output logic        out_tlast,  // last_row
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = mdl_pkg::ADDR_W;
  localparam int CW = mdl_pkg::COL_W;
  localparam int RW = mdl_pkg::ROW_W;
  localparam int QD = 4;
  localparam int LAT = 6;

  // Config registers
  logic signed [15:0] gain_r, thr_r;
  logic [4:0] nin_r, nout_r;
  logic cfg_we;
  mdl_pkg::reg_t cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_we  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = mdl_pkg::reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 16'sd154;
      thr_r  <= 16'sd128;
      nin_r  <= 5'd16;
      nout_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_idx)
        mdl_pkg::REG_GAIN:   gain_r <= cfg_pwdata[15:0];
        mdl_pkg::REG_THRESH: thr_r  <= cfg_pwdata[15:0];
        mdl_pkg::REG_NIN:    nin_r  <= cfg_pwdata[4:0];
        mdl_pkg::REG_NOUT:   nout_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mdl_pkg::REG_GAIN:   cfg_prdata = {{16{gain_r[15]}}, gain_r};
      mdl_pkg::REG_THRESH: cfg_prdata = {{16{thr_r[15]}}, thr_r};
      mdl_pkg::REG_NIN:    cfg_prdata = {27'd0, nin_r};
      mdl_pkg::REG_NOUT:   cfg_prdata = {27'd0, nout_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // Clamped sizes
  logic [4:0] n_in, n_out;
  always_comb begin
    n_in  = (nin_r == 5'd0) ? 5'd1 : ((nin_r > 5'(mdl_pkg::MAX_INPUTS)) ?
            5'(mdl_pkg::MAX_INPUTS) : nin_r);
    n_out = (nout_r == 5'd0) ? 5'd1 : ((nout_r > 5'(mdl_pkg::MAX_OUTPUTS)) ?
            5'(mdl_pkg::MAX_OUTPUTS) : nout_r);
  end

  // Input fields
  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic signed [15:0] in_value;
  mdl_pkg::func_t in_func;
  assign in_row   = in_tdata[3:0];
  assign in_col   = in_tdata[7:4];
  assign in_value = in_tdata[23:8];
  assign in_func  = mdl_pkg::func_t'(in_tuser);

  // Sequencer
  mdl_pkg::state_t st_r, st_nxt;
  logic [AW:0] sweep_r;
  logic sweeping;
  logic [CW-1:0] ci_r;
  logic [RW-1:0] ri_r;
  logic [2:0] drain_r;
  logic issue, stall, in_acc;
  logic [2:0] q_cnt_r;
  logic [3:0] inflight_r;

  assign sweeping = !sweep_r[AW];
  // Stall while results could overflow the queue
  assign stall = (4'(q_cnt_r) + inflight_r) >= 4'(QD);
  assign in_tready = (st_r == mdl_pkg::ST_IDLE) && !sweeping;
  assign in_acc = in_tvalid && in_tready;
  assign issue = (st_r == mdl_pkg::ST_RUN) && !stall;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mdl_pkg::ST_IDLE:
        if (in_acc && in_func == mdl_pkg::FN_FEATURE && in_tlast) begin
          st_nxt = mdl_pkg::ST_RUN;
        end
      mdl_pkg::ST_RUN:
        if (issue && 5'(ci_r) == n_in - 5'd1 && 5'(ri_r) == n_out - 5'd1) begin
          st_nxt = mdl_pkg::ST_FINISH;
        end
      mdl_pkg::ST_FINISH:
        if (drain_r == 3'(LAT)) begin
          st_nxt = mdl_pkg::ST_IDLE;
        end
      default: st_nxt = mdl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mdl_pkg::ST_IDLE;
      sweep_r <= '0;
      ci_r <= '0;
      ri_r <= '0;
      drain_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (sweeping) sweep_r <= sweep_r + 1'b1;
      if (st_r == mdl_pkg::ST_FINISH) drain_r <= drain_r + 3'd1;
      else drain_r <= '0;
      if (issue) begin
        if (5'(ci_r) == n_in - 5'd1) begin
          ci_r <= '0;
          ri_r <= (5'(ri_r) == n_out - 5'd1) ? '0 : ri_r + 1'b1;
        end else begin
          ci_r <= ci_r + 1'b1;
        end
      end
    end
  end

  // Stores
  logic col_ok, row_ok;
  assign col_ok = 32'(in_col) < mdl_pkg::MAX_INPUTS;
  assign row_ok = 32'(in_row) < mdl_pkg::MAX_OUTPUTS;
  logic [AW-1:0] waddr, raddr;
  assign waddr = {in_row, in_col};
  assign raddr = {ri_r, ci_r};
  logic w_we, m_we;
  logic [14:0] m_wdata, m_clamp;
  logic [AW-1:0] m_waddr;
  logic signed [15:0] w_rd;
  logic [14:0] m_rd;
  assign w_we = in_acc && in_func == mdl_pkg::FN_WEIGHT && row_ok && col_ok;
  assign m_clamp = in_value[15] ? 15'd0 :
                   (in_value > 16'sd16384 ? 15'(mdl_pkg::MASK_ONE) : in_value[14:0]);
  assign m_we = sweeping || (in_acc && in_func == mdl_pkg::FN_MASK && row_ok && col_ok);
  assign m_waddr = sweeping ? sweep_r[AW-1:0] : waddr;
  assign m_wdata = sweeping ? 15'(mdl_pkg::MASK_ONE) : m_clamp;

  mdl_ram #(.WIDTH(16), .DEPTH(mdl_pkg::DEPTH)) u_wram (
    .clk(clk), .we(w_we), .waddr(waddr), .wdata(in_value),
    .raddr(raddr), .rdata(w_rd));
  mdl_ram #(.WIDTH(15), .DEPTH(mdl_pkg::DEPTH)) u_mram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(raddr), .rdata(m_rd));

  logic signed [15:0] bias_r [mdl_pkg::MAX_OUTPUTS];
  logic signed [15:0] feat_r [mdl_pkg::MAX_INPUTS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < mdl_pkg::MAX_OUTPUTS; k++) bias_r[k] <= '0;
    end else if (in_acc && in_func == mdl_pkg::FN_BIAS && row_ok) begin
      bias_r[in_row] <= in_value;
    end
  end
  always_ff @(posedge clk) begin
    if (in_acc && in_func == mdl_pkg::FN_FEATURE && col_ok) feat_r[in_col] <= in_value;
  end

  // Tag for the term at the RAM read stage
  mdl_pkg::tag_t t0_r;
  logic [CW-1:0] c0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) t0_r.valid <= 1'b0;
    else t0_r.valid <= issue;
    t0_r.first <= (ci_r == '0);
    t0_r.last  <= (5'(ci_r) == n_in - 5'd1);
    t0_r.row   <= ri_r;
    c0_r <= ci_r;
  end

  // Cell 1: masked weight = floor(w*c/2^14)
  mdl_pkg::tag_t t1, t2, t4;
  logic signed [mdl_pkg::ACC_W-1:0] p1, p2, p4;
  logic signed [15:0] f1_r;
  mdl_cell u_mask (
    .clk(clk), .rst_n(rst_n), .tag_in(t0_r),
    .a_in(mdl_pkg::ACC_W'(w_rd)), .b_in({2'b00, m_rd}), .shift14(1'b1),
    .tag_out(t1), .p_out(p1));
  always_ff @(posedge clk) f1_r <= feat_r[c0_r];

  // Cell 2: masked weight times feature
  mdl_cell u_feat (
    .clk(clk), .rst_n(rst_n), .tag_in(t1),
    .a_in(p1), .b_in(17'(f1_r)), .shift14(1'b0),
    .tag_out(t2), .p_out(p2));

  // Accumulate products of one row
  mdl_pkg::tag_t t3_r;
  logic signed [mdl_pkg::ACC_W-1:0] acc_r, acc_nxt;
  assign acc_nxt = (t2.first ? '0 : acc_r) + p2;
  always_ff @(posedge clk) begin
    if (!rst_n) t3_r.valid <= 1'b0;
    else t3_r.valid <= t2.valid && t2.last;
    t3_r.first <= 1'b0;
    t3_r.last  <= (5'(t2.row) == n_out - 5'd1);
    t3_r.row   <= t2.row;
    if (t2.valid) acc_r <= acc_nxt;
  end

  // Cell 3: scale by gain (low part kept by the wide product then shifted)
  logic signed [mdl_pkg::ACC_W+16:0] scaled_r;
  mdl_pkg::tag_t t4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) t4_r.valid <= 1'b0;
    else t4_r.valid <= t3_r.valid;
    t4_r.first <= 1'b0;
    t4_r.last  <= t3_r.last;
    t4_r.row   <= t3_r.row;
    scaled_r   <= acc_r * gain_r;
  end
  assign t4 = t4_r;
  assign p4 = mdl_pkg::ACC_W'((scaled_r + (mdl_pkg::ACC_W+17)'(1 << 23)) >>> 24);

  // Bias, saturate, threshold
  logic signed [mdl_pkg::ACC_W:0] v;
  logic signed [15:0] vs;
  logic sat, on;
  always_comb begin
    v = (mdl_pkg::ACC_W+1)'(p4) + (mdl_pkg::ACC_W+1)'(bias_r[t4.row]);
    sat = 1'b0;
    vs = v[15:0];
    if (v > 32767) begin vs = 16'sh7fff; sat = 1'b1; end
    if (v < -32768) begin vs = -16'sh8000; sat = 1'b1; end
    on = vs > thr_r;
  end

  // Path bits
  logic [mdl_pkg::MAX_OUTPUTS-1:0] path_r;
  always_ff @(posedge clk) begin
    if (!rst_n) path_r <= '0;
    else if (t4.valid) path_r[t4.row] <= on;
  end

  // Result queue
  logic [23:0] q_data [QD];
  logic q_last [QD];
  logic [1:0] q_wp_r, q_rp_r;
  logic q_pop;
  assign q_pop = out_tvalid && out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r <= '0; q_rp_r <= '0; q_cnt_r <= '0;
    end else begin
      if (t4.valid) q_wp_r <= q_wp_r + 2'd1;
      if (q_pop) q_rp_r <= q_rp_r + 2'd1;
      q_cnt_r <= q_cnt_r + 3'(t4.valid) - 3'(q_pop);
    end
    if (t4.valid) begin
      q_data[q_wp_r] <= {2'b00, sat, on, vs, t4.row};
      q_last[q_wp_r] <= t4.last;
    end
  end
  assign out_tvalid = q_cnt_r != '0;
  assign out_tdata  = q_data[q_rp_r];
  assign out_tlast  = q_last[q_rp_r];

  // Count rows whose result is still in the chain
  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= inflight_r + 4'(issue && 5'(ci_r) == n_in - 5'd1)
                       - 4'(t4.valid);
  end

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 3'(QD))
    else $error("result queue overflow");
  a_no_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != mdl_pkg::ST_IDLE |-> !in_tready) else $error("input taken during run");
  a_sweep_hold: assert property (@(posedge clk) disable iff (!rst_n)
    sweeping |-> !in_tready && st_r == mdl_pkg::ST_IDLE) else $error("input during sweep");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == mdl_pkg::ST_IDLE |-> inflight_r == '0) else $error("rows lost in chain");
`endif

endmodule

// File: dv/tb_masked_dense_layer_forward.sv
// ----------------------------------------------------------------------------
// tb_masked_dense_layer_forward
// Self-checking bench for the masked dense layer: writes weights, masks,
// biases and features over the input stream, predicts every row result and
// compares it with the output stream under random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_masked_dense_layer_forward;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mdl_pkg::func_t fn;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] value;
    logic        last;
  } layer_cmd_t;

  typedef struct packed {
    logic [3:0]  row;
    logic [15:0] value;
    logic        path_on;
    logic        sat;
    logic        last;
  } row_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  masked_dense_layer_forward dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the block's state
  logic signed [15:0] weights [mdl_pkg::DEPTH];
  logic [14:0]        masks [mdl_pkg::DEPTH];
  logic signed [15:0] biases [mdl_pkg::MAX_OUTPUTS];
  logic signed [15:0] features [mdl_pkg::MAX_INPUTS];
  logic signed [15:0] gain_q = 16'sd154;
  logic signed [15:0] thresh_q = 16'sd128;
  logic [4:0]         n_in_reg = 5'd16;
  logic [4:0]         n_out_reg = 5'd16;

  layer_cmd_t  pending_cmds [$];
  row_result_t expected_rows [$];
  int          errors = 0;
  bit          stim_done = 0;
  bit          driver_hold = 0;

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Update the shadow state and queue the rows a run produces
  task automatic predict_layer(input layer_cmd_t c);
    int ni, no;
    longint acc, mw, t, q, v;
    logic [15:0] m;
    ni = (n_in_reg < 1) ? 1 : (n_in_reg > mdl_pkg::MAX_INPUTS ? mdl_pkg::MAX_INPUTS
                                                                : int'(n_in_reg));
    no = (n_out_reg < 1) ? 1 : (n_out_reg > mdl_pkg::MAX_OUTPUTS ? mdl_pkg::MAX_OUTPUTS
                                                                 : int'(n_out_reg));
    case (c.fn)
      mdl_pkg::FN_WEIGHT: weights[{c.row, c.col}] = c.value;
      mdl_pkg::FN_MASK: begin
        if ($signed(c.value) < 0) m = '0;
        else if ($signed(c.value) > mdl_pkg::MASK_ONE) m = 16'(mdl_pkg::MASK_ONE);
        else m = c.value;
        masks[{c.row, c.col}] = m[14:0];
      end
      mdl_pkg::FN_BIAS: biases[c.row] = c.value;
      mdl_pkg::FN_FEATURE: begin
        features[c.col] = c.value;
        if (c.last) begin
          for (int r = 0; r < no; r++) begin
            row_result_t e;
            acc = 0;
            for (int i = 0; i < ni; i++) begin
              mw = (longint'(weights[r*mdl_pkg::MAX_INPUTS+i]) *
                    longint'({1'b0, masks[r*mdl_pkg::MAX_INPUTS+i]})) >>> 14;
              acc += mw * longint'(features[i]);
            end
            t = acc * longint'(gain_q) + (64'sd1 <<< 23);
            q = t >>> 24;
            v = q + longint'(biases[r]);
            e.sat = 1'b0;
            if (v > 32767) begin v = 32767; e.sat = 1'b1; end
            if (v < -32768) begin v = -32768; e.sat = 1'b1; end
            e.row = r[3:0];
            e.value = v[15:0];
            e.path_on = v > longint'(thresh_q);
            e.last = (r + 1 == no);
            expected_rows.push_back(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver: present queued commands with random gaps
  int in_gap = 0;
  always @(posedge clk) begin
    layer_cmd_t c;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_layer(pending_cmds.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap == 0 && !driver_hold && pending_cmds.size() > 0) begin
          c = pending_cmds[0];
          in_tvalid <= 1'b1;
          in_tdata <= {c.value, c.col, c.row};
          in_tuser <= c.fn;
          in_tlast <= c.last;
          in_gap <= short_gap();
        end else begin
          in_tvalid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end
      end
    end
  end

  // Monitor: compare each row result with the oldest prediction
  int out_gap = 0;
  always @(posedge clk) begin
    row_result_t got, e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[3:0], out_tdata[19:4], out_tdata[20], out_tdata[21], out_tlast};
        if (expected_rows.size() == 0) begin
          $display("%0t: exp no result got %h", $time, got);
          errors++;
        end else begin
          e = expected_rows.pop_front();
          if (got.row !== e.row) begin
            $display("%0t: row exp %0d got %0d", $time, e.row, got.row); errors++;
          end
          if (got.value !== e.value) begin
            $display("%0t: value exp %h got %h", $time, e.value, got.value); errors++;
          end
          if (got.path_on !== e.path_on) begin
            $display("%0t: path exp %b got %b", $time, e.path_on, got.path_on); errors++;
          end
          if (got.sat !== e.sat) begin
            $display("%0t: sat exp %b got %b", $time, e.sat, got.sat); errors++;
          end
          if (got.last !== e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, got.last); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap <= short_gap();
      end
    end
  end

  task automatic push_cmd(input mdl_pkg::func_t fn, input int row, input int col,
                          input logic [15:0] value, input bit last);
    layer_cmd_t c;
    c.fn = fn; c.row = 4'(row); c.col = 4'(col); c.value = value; c.last = last;
    pending_cmds.push_back(c);
  endtask

  // Block until the block is idle, then let the pipeline drain
  task automatic wait_idle();
    while (pending_cmds.size() > 0 || in_tvalid || expected_rows.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input mdl_pkg::reg_t idx, input logic [15:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      mdl_pkg::REG_GAIN:   gain_q = value;
      mdl_pkg::REG_THRESH: thresh_q = value;
      mdl_pkg::REG_NIN:    n_in_reg = value[4:0];
      mdl_pkg::REG_NOUT:   n_out_reg = value[4:0];
      default: ;
    endcase
  endtask

  // Random samples: weight, mask and bias writes and features, each closed by a last feature
  task automatic random_samples(input int count, input int wide);
    for (int s = 0; s < count; s++) begin
      int nw;
      nw = $urandom_range(0, 6);
      for (int k = 0; k < nw; k++) begin
        case ($urandom_range(0, 2))
          0: push_cmd(mdl_pkg::FN_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 15),
                      wide ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512),
                      1'($urandom_range(0, 1)));
          1: push_cmd(mdl_pkg::FN_MASK, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 3) == 0 ? 16'($urandom) :
                      16'($urandom_range(0, 16384)), 1'($urandom_range(0, 1)));
          default: push_cmd(mdl_pkg::FN_BIAS, $urandom_range(0, 15), 0, 16'($urandom),
                            1'($urandom_range(0, 1)));
        endcase
      end
      nw = $urandom_range(0, 5);
      for (int k = 0; k < nw; k++)
        push_cmd(mdl_pkg::FN_FEATURE, 0, $urandom_range(0, 15),
                 wide ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024), 1'b0);
      push_cmd(mdl_pkg::FN_FEATURE, 0, $urandom_range(0, 15), 16'($urandom), 1'b1);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Define every weight and feature so nothing undefined is read
    for (int i = 0; i < mdl_pkg::DEPTH; i++) begin
      weights[i] = 0; masks[i] = 15'(mdl_pkg::MASK_ONE);
    end
    for (int i = 0; i < mdl_pkg::MAX_OUTPUTS; i++) biases[i] = 0;
    for (int i = 0; i < mdl_pkg::MAX_INPUTS; i++) features[i] = 0;
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        push_cmd(mdl_pkg::FN_WEIGHT, r, c, 16'($urandom_range(0, 1023) - 512), 1'b0);
    for (int c = 0; c < 16; c++)
      push_cmd(mdl_pkg::FN_FEATURE, 0, c, 16'($urandom_range(0, 511)), 1'b0);
    wait_idle();

    // Directed: field extremes, mask clamping, last on writes, full swing
    push_cmd(mdl_pkg::FN_MASK, 0, 0, 16'h8000, 1'b1);
    push_cmd(mdl_pkg::FN_MASK, 0, 1, 16'h7fff, 1'b0);
    push_cmd(mdl_pkg::FN_MASK, 15, 15, 16'd0, 1'b0);
    push_cmd(mdl_pkg::FN_WEIGHT, 0, 2, 16'h7fff, 1'b1);
    push_cmd(mdl_pkg::FN_WEIGHT, 15, 0, 16'h8000, 1'b0);
    push_cmd(mdl_pkg::FN_BIAS, 1, 0, 16'h7fff, 1'b1);
    push_cmd(mdl_pkg::FN_BIAS, 2, 15, 16'h8000, 1'b0);
    push_cmd(mdl_pkg::FN_FEATURE, 0, 2, 16'h7fff, 1'b0);
    push_cmd(mdl_pkg::FN_FEATURE, 0, 15, 16'h8000, 1'b1);
    push_cmd(mdl_pkg::FN_WEIGHT, 3, 0, 16'h7fff, 1'b0);
    push_cmd(mdl_pkg::FN_WEIGHT, 3, 1, 16'h7fff, 1'b0);
    push_cmd(mdl_pkg::FN_FEATURE, 0, 0, 16'h7fff, 1'b0);
    push_cmd(mdl_pkg::FN_FEATURE, 0, 1, 16'h7fff, 1'b1);
    push_cmd(mdl_pkg::FN_FEATURE, 15, 1, 16'h8000, 1'b1);
    wait_idle();

    write_reg(mdl_pkg::REG_GAIN, 16'h7fff);
    write_reg(mdl_pkg::REG_THRESH, 16'h8000);
    write_reg(mdl_pkg::REG_NIN, 16'd1);
    write_reg(mdl_pkg::REG_NOUT, 16'd1);
    random_samples(2, 1);
    wait_idle();
    write_reg(mdl_pkg::REG_GAIN, 16'h8000);
    write_reg(mdl_pkg::REG_THRESH, 16'h7fff);
    write_reg(mdl_pkg::REG_NIN, 16'd0);
    write_reg(mdl_pkg::REG_NOUT, 16'd31);
    random_samples(2, 1);
    wait_idle();
    write_reg(mdl_pkg::REG_GAIN, 16'd256);
    write_reg(mdl_pkg::REG_THRESH, 16'd0);
    write_reg(mdl_pkg::REG_NIN, 16'd4);
    write_reg(mdl_pkg::REG_NOUT, 16'd3);
    random_samples(5, 0);
    // Hold the sender part way through until all rows have arrived
    while (pending_cmds.size() > 12) @(posedge clk);
    driver_hold = 1;
    while (in_tvalid || expected_rows.size() > 0) @(posedge clk);
    driver_hold = 0;
    wait_idle();
    write_reg(mdl_pkg::REG_GAIN, 16'd154);
    write_reg(mdl_pkg::REG_THRESH, 16'd128);
    write_reg(mdl_pkg::REG_NIN, 16'd16);
    write_reg(mdl_pkg::REG_NOUT, 16'd16);
    random_samples(2, 0);
    wait_idle();
    write_reg(mdl_pkg::REG_NIN, 16'd7);
    write_reg(mdl_pkg::REG_NOUT, 16'd9);
    random_samples(3, 1);
    wait_idle();
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) $display("tb_masked_dense_layer_forward: PASS");
    else $display("tb_masked_dense_layer_forward: FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_masked_dense_layer_forward: FAIL");
    $finish;
  end
endmodule

// File: filelist.f
design/mdl_pkg.sv
design/mdl_ram.sv
design/mdl_cell.sv
design/masked_dense_layer_forward.sv
dv/tb_masked_dense_layer_forward.sv
